// ===== rtl/core/sha1_stream_hasher_defines.svh =====
// ---------------------------------------------------------------------------
// SHA-1 stream hasher assertion macros
// Shared property shorthands for the hasher's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset
`define SHA1S_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous active-low reset
`define SHA1S_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sha1s_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-1 stream hasher package
// Constants, round functions and control structs shared by the hasher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1s_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NWORDS  = 5;
  localparam int unsigned BLOCK_W = 512;
  localparam int unsigned ROUNDS  = 80;

  localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
  localparam logic [WORD_W-1:0] IV1 = 32'hEFCDAB89;
  localparam logic [WORD_W-1:0] IV2 = 32'h98BADCFE;
  localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
  localparam logic [WORD_W-1:0] IV4 = 32'hC3D2E1F0;

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Request from the sequencer to the round engine
  typedef struct packed {
    logic start;  // load working words, begin 80 rounds
    logic init;   // restore chaining words to the initial values
  } core_ctl_t;

  // Status from the round engine
  typedef struct packed {
    logic busy;   // rounds or fold in progress
    logic adv;    // schedule advances this cycle
    logic done;   // chaining words update at this edge
  } core_sts_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

// ===== rtl/core/sha1s_sched.sv =====
// ---------------------------------------------------------------------------
// SHA-1 message schedule
// Sixteen-word shift window: load a block, then shift one expanded word per round.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1s_sched (
  input  logic                            clk,
  input  logic                            load_i,
  input  logic                            adv_i,
  input  logic [sha1s_pkg::BLOCK_W-1:0]   block_i,
  output logic [sha1s_pkg::WORD_W-1:0]    w_o
);

  logic [15:0][sha1s_pkg::WORD_W-1:0] win_r;
  logic [sha1s_pkg::WORD_W-1:0]       new_w;

  assign new_w = sha1s_pkg::rotl(win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0], 1);
  assign w_o   = win_r[0];

  always_ff @(posedge clk) begin
    if (load_i) begin
      for (int i = 0; i < 16; i++) begin
        win_r[i] <= block_i[sha1s_pkg::BLOCK_W-1-32*i -: 32];
      end
    end else if (adv_i) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= new_w;
    end
  end

endmodule

// ===== rtl/core/sha1s_round.sv =====
// ---------------------------------------------------------------------------
// SHA-1 round engine
// One shared round adder, stepped 80 times per block, then folded into H.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha1_stream_hasher_defines.svh"

module sha1s_round (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  sha1s_pkg::core_ctl_t                         ctl_i,
  input  logic [sha1s_pkg::WORD_W-1:0]                 w_i,
  output sha1s_pkg::core_sts_t                         sts_o,
  output logic [sha1s_pkg::NWORDS-1:0][sha1s_pkg::WORD_W-1:0] h_o
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RUN  = 2'd1;
  localparam logic [1:0] C_FOLD = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [sha1s_pkg::NWORDS-1:0][sha1s_pkg::WORD_W-1:0] h_r, h_nxt;
  logic [sha1s_pkg::NWORDS-1:0][sha1s_pkg::WORD_W-1:0] wk_r, wk_nxt;
  logic [sha1s_pkg::WORD_W-1:0] f, k, t;

  // Round function and constant by quarter
  always_comb begin
    if (rnd_r inside {[7'd0:7'd19]}) begin
      f = (wk_r[1] & wk_r[2]) | (~wk_r[1] & wk_r[3]);
      k = sha1s_pkg::K0;
    end else if (rnd_r inside {[7'd20:7'd39]}) begin
      f = wk_r[1] ^ wk_r[2] ^ wk_r[3];
      k = sha1s_pkg::K1;
    end else if (rnd_r inside {[7'd40:7'd59]}) begin
      f = (wk_r[1] & wk_r[2]) | (wk_r[1] & wk_r[3]) | (wk_r[2] & wk_r[3]);
      k = sha1s_pkg::K2;
    end else begin
      f = wk_r[1] ^ wk_r[2] ^ wk_r[3];
      k = sha1s_pkg::K3;
    end
    t = sha1s_pkg::rotl(wk_r[0], 5) + f + wk_r[4] + k + w_i;
  end

  always_comb begin
    st_nxt  = st_r;
    rnd_nxt = rnd_r;
    h_nxt   = h_r;
    wk_nxt  = wk_r;
    case (st_r)
      C_IDLE: begin
        if (ctl_i.init) begin
          h_nxt = {sha1s_pkg::IV4, sha1s_pkg::IV3, sha1s_pkg::IV2,
                   sha1s_pkg::IV1, sha1s_pkg::IV0};
        end
        if (ctl_i.start) begin
          wk_nxt  = h_r;
          rnd_nxt = '0;
          st_nxt  = C_RUN;
        end
      end
      C_RUN: begin
        wk_nxt[4] = wk_r[3];
        wk_nxt[3] = wk_r[2];
        wk_nxt[2] = sha1s_pkg::rotl(wk_r[1], 30);
        wk_nxt[1] = wk_r[0];
        wk_nxt[0] = t;
        if (rnd_r == 7'(sha1s_pkg::ROUNDS - 1)) begin
          rnd_nxt = '0;
          st_nxt  = C_FOLD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      C_FOLD: begin
        for (int i = 0; i < sha1s_pkg::NWORDS; i++) begin
          h_nxt[i] = h_r[i] + wk_r[i];
        end
        st_nxt = C_IDLE;
      end
      default: begin
        st_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= C_IDLE;
      rnd_r <= '0;
      h_r   <= {sha1s_pkg::IV4, sha1s_pkg::IV3, sha1s_pkg::IV2,
                sha1s_pkg::IV1, sha1s_pkg::IV0};
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
      h_r   <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r <= wk_nxt;
  end

  assign sts_o.busy = (st_r != C_IDLE);
  assign sts_o.adv  = (st_r == C_RUN);
  assign sts_o.done = (st_r == C_FOLD);
  assign h_o        = h_r;

  `SHA1S_ASSERT_IMP(a_rnd_range, clk, rst_n, st_r == C_RUN, rnd_r < 7'(sha1s_pkg::ROUNDS), "round index out of range")
  `SHA1S_ASSERT_NXT(a_fold_after_last, clk, rst_n, st_r == C_RUN && rnd_r == 7'(sha1s_pkg::ROUNDS - 1), st_r == C_FOLD, "fold did not follow the last round")

endmodule

// ===== rtl/core/sha1_stream_hasher.sv =====
// ---------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte-stream SHA-1: packs bytes into 512-bit blocks, pads, emits the digest.
// ---------------------------------------------------------------------------
//  Channel  Dir   tdata                 tuser           tlast
//  in_      in    [7:0] data_byte       byte_present    end_of_message
//  out_     out   [31:0] digest_word    -               word_last
//
//  The 64th byte of a block starts a compression (load, 80 rounds through the
//  one round adder, fold), during which in_tready stays low. An end item pads
//  one byte per cycle, pausing while each full padded block is compressed (one
//  compression, or two when the length does not fit), then loads five digest words.
//  Reset (rst_n low, synchronous) restores the initial chaining words and clears
//  the byte count. A stalled out_ side holds the current word; the next item
//  is accepted while the last digest word still waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha1_stream_hasher_defines.svh"

module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // word_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;        // bytes in the current block
  logic [63:0] len_r, len_nxt;          // message length in bits
  logic [sha1s_pkg::BLOCK_W-1:0] block_r, block_nxt;
  logic        pad_r, pad_nxt;          // end seen, padding owed
  logic        mark_r, mark_nxt;        // 0x80 marker placed
  logic        lenok_r, lenok_nxt;      // this block carries the length
  logic        final_r, final_nxt;      // block in flight is the last
  logic [2:0]  idx_r, idx_nxt;          // digest word to load
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  logic        put_en;
  logic [7:0]  put_byte;
  logic [7:0]  len_byte;
  sha1s_pkg::core_ctl_t ctl;
  sha1s_pkg::core_sts_t sts;
  logic [31:0] sched_w;
  logic [sha1s_pkg::NWORDS-1:0][31:0] h;

  assign in_tready = (state_r == ST_IDLE);

  // Length byte for block positions 56..63, most significant first
  assign len_byte = 8'(len_r >> {~fill_r[2:0], 3'b000});

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    block_nxt     = block_r;
    pad_nxt       = pad_r;
    mark_nxt      = mark_r;
    lenok_nxt     = lenok_r;
    final_nxt     = final_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    put_en        = 1'b0;
    put_byte      = '0;
    ctl           = '0;

    // drop the held word once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            put_en   = 1'b1;
            put_byte = in_tdata;
            len_nxt  = len_r + 64'd8;
          end
          if (in_tlast) begin
            pad_nxt = 1'b1;
          end
          if (in_tuser && fill_r == 6'd63) begin
            state_nxt = ST_LOAD;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        put_en   = 1'b1;
        mark_nxt = 1'b1;
        if (!mark_r) begin
          put_byte  = sha1s_pkg::PAD_MARK;
          lenok_nxt = (fill_r < 6'd56);
        end else if (lenok_r && fill_r >= 6'd56) begin
          put_byte = len_byte;
        end else begin
          put_byte = 8'h00;
        end
        if (fill_r == 6'd63) begin
          final_nxt = mark_r & lenok_r;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl.start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.done) begin
          if (final_r) begin
            idx_nxt   = '0;
            state_nxt = ST_OUT;
          end else if (pad_r) begin
            // a marker already placed means the length goes in this next block
            lenok_nxt = mark_r;
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = h[idx_r];
          out_last_nxt  = (idx_r == 3'(sha1s_pkg::NWORDS - 1));
          idx_nxt       = idx_r + 3'd1;
          if (idx_r == 3'(sha1s_pkg::NWORDS - 1)) begin
            // restart for the next message
            ctl.init  = 1'b1;
            len_nxt   = '0;
            pad_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            lenok_nxt = 1'b0;
            final_nxt = 1'b0;
            idx_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // advance the block shift register by one byte
    if (put_en) begin
      block_nxt = {block_r[sha1s_pkg::BLOCK_W-9:0], put_byte};
      fill_nxt  = fill_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      pad_r       <= 1'b0;
      mark_r      <= 1'b0;
      lenok_r     <= 1'b0;
      final_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      pad_r       <= pad_nxt;
      mark_r      <= mark_nxt;
      lenok_r     <= lenok_nxt;
      final_r     <= final_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    block_r    <= block_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  sha1s_sched u_sched (
    .clk     (clk),
    .load_i  (ctl.start),
    .adv_i   (sts.adv),
    .block_i (block_r),
    .w_o     (sched_w)
  );

  sha1s_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl),
    .w_i   (sched_w),
    .sts_o (sts),
    .h_o   (h)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `SHA1S_ASSERT_IMP(a_done_in_wait, clk, rst_n, sts.done, state_r == ST_WAIT, "compression finished outside wait")
  `SHA1S_ASSERT_IMP(a_start_idle_core, clk, rst_n, ctl.start, !sts.busy, "compression started while engine busy")
  `SHA1S_ASSERT_IMP(a_last_word_left_out, clk, rst_n, out_tvalid && out_tlast, state_r != ST_OUT || idx_r == 3'd0, "still loading digest after last word")
  `SHA1S_ASSERT_IMP(a_out_block_empty, clk, rst_n, state_r == ST_OUT, fill_r == 6'd0, "digest loaded with bytes pending")

endmodule
